### rtl/core/apw_pkg.sv
// Package: shared constants, register codes and the front-to-back command word.
`default_nettype none

package apw_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int IDX_W          = 7;
	localparam int SUM_DEPTH      = 128;
	localparam int CFG_W          = 9;
	localparam int APB_AW         = 3;
	localparam int APB_DW         = 32;
	localparam int QUEUE_DEPTH    = 4;

	localparam int POOL_SIZE_DEF  = 2;
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam logic [CFG_W-1:0] ROW_LENGTH_RST = 9'd24;
	localparam logic [CFG_W-1:0] ROW_TOTAL_RST  = 9'd24;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_ROW_LENGTH = 1'b0,
		REG_ROW_TOTAL  = 1'b1
	} reg_idx_t;

	// position of a window in the pooled map
	typedef struct packed {
		logic [IDX_W-1:0] wr;
		logic [IDX_W-1:0] wc;
		logic             frame_last;
	} tag_t;

	// one in-window sample with its place inside the window
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       cc_first;
		logic                       cc_last;
		logic                       rr_first;
		logic                       rr_last;
		tag_t                       tag;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/core/apw_stream_if.sv
// Interfaces: valid/ready channels for feature samples and pooled words.
`default_nettype none

interface apw_feature_if;
	logic                 valid;
	logic                 ready;
	logic signed [15:0]   sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface apw_pooled_if;
	logic                 valid;
	logic                 ready;
	logic signed [15:0]   average;
	logic [6:0]           out_row;
	logic [6:0]           out_col;
	logic                 frame_last;

	modport source (output valid, output average, output out_row, output out_col,
		output frame_last, input ready);
	modport sink   (input valid, input average, input out_row, input out_col,
		input frame_last, output ready);
endinterface

`default_nettype wire

### rtl/core/apw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module apw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/apw_front.sv
// Front end: raster counters, window classification, command push.
`default_nettype none

module apw_front #(
	parameter int POOL_SIZE  = apw_pkg::POOL_SIZE_DEF,
	parameter int MAX_WIDTH  = apw_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = apw_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	apw_feature_if.sink                      feature,
	input  wire logic [apw_pkg::CFG_W-1:0]   row_length,
	input  wire logic [apw_pkg::CFG_W-1:0]   row_total,
	output logic                             push_valid,
	input  wire logic                        push_ready,
	output apw_pkg::cmd_t                    push_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int CMPW = ((CW > apw_pkg::CFG_W) ? CW : apw_pkg::CFG_W) + 2;
	localparam int RMPW = ((RW > apw_pkg::CFG_W) ? RW : apw_pkg::CFG_W) + 2;
	localparam int PCW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int IW   = apw_pkg::IDX_W;

	logic [CW-1:0]  col_q, wc_q;
	logic [RW-1:0]  row_q, wr_q;
	logic [PCW-1:0] cc_q, rr_q;

	logic [CMPW-1:0] width_c, col_ext, wstart_c, cfg_w_ext;
	logic [RMPW-1:0] height_c, row_ext, wstart_r, cfg_h_ext;
	logic            in_col, in_row, last_col, last_row, col_wrap, row_wrap;
	logic            cc_end, rr_end, accept;

	// clamp the map size to [2, MAX]
	always_comb begin
		cfg_w_ext = CMPW'(row_length);
		cfg_h_ext = RMPW'(row_total);
		if (cfg_w_ext < CMPW'(2)) width_c = CMPW'(2);
		else if (cfg_w_ext > CMPW'(MAX_WIDTH)) width_c = CMPW'(MAX_WIDTH);
		else width_c = cfg_w_ext;
		if (cfg_h_ext < RMPW'(2)) height_c = RMPW'(2);
		else if (cfg_h_ext > RMPW'(MAX_HEIGHT)) height_c = RMPW'(MAX_HEIGHT);
		else height_c = cfg_h_ext;
	end

	// a window fits when its first position plus POOL_SIZE stays within the map;
	// it is the last one when the next window would not fit
	always_comb begin
		col_ext  = CMPW'(col_q);
		row_ext  = RMPW'(row_q);
		wstart_c = col_ext - CMPW'(cc_q);
		wstart_r = row_ext - RMPW'(rr_q);
		in_col   = (wstart_c + CMPW'(POOL_SIZE)) <= width_c;
		in_row   = (wstart_r + RMPW'(POOL_SIZE)) <= height_c;
		last_col = (wstart_c + CMPW'(2 * POOL_SIZE)) > width_c;
		last_row = (wstart_r + RMPW'(2 * POOL_SIZE)) > height_c;
		col_wrap = (col_ext + CMPW'(1)) >= width_c;
		row_wrap = (row_ext + RMPW'(1)) >= height_c;
		cc_end   = cc_q == PCW'(POOL_SIZE - 1);
		rr_end   = rr_q == PCW'(POOL_SIZE - 1);
	end

	assign feature.ready = push_ready;
	assign accept        = feature.valid && push_ready;
	assign push_valid    = feature.valid && in_col && in_row;

	always_comb begin
		push_data.sample         = feature.sample;
		push_data.cc_first       = cc_q == '0;
		push_data.cc_last        = cc_end;
		push_data.rr_first       = rr_q == '0;
		push_data.rr_last        = rr_end;
		push_data.tag.wr         = IW'(wr_q);
		push_data.tag.wc         = IW'(wc_q);
		push_data.tag.frame_last = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			cc_q  <= '0;
			wc_q  <= '0;
			row_q <= '0;
			rr_q  <= '0;
			wr_q  <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				cc_q  <= '0;
				wc_q  <= '0;
				if (row_wrap) begin
					row_q <= '0;
					rr_q  <= '0;
					wr_q  <= '0;
				end else begin
					row_q <= row_q + RW'(1);
					rr_q  <= rr_end ? '0 : rr_q + PCW'(1);
					wr_q  <= rr_end ? wr_q + RW'(1) : wr_q;
				end
			end else begin
				col_q <= col_q + CW'(1);
				cc_q  <= cc_end ? '0 : cc_q + PCW'(1);
				wc_q  <= cc_end ? wc_q + CW'(1) : wc_q;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/apw_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module apw_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire apw_pkg::cmd_t  push_data,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output apw_pkg::cmd_t       pop_data
);

	localparam int DEPTH = apw_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	apw_pkg::cmd_t  slot_q [DEPTH];
	logic [AW-1:0]  wptr_q, rptr_q;
	logic [AW:0]    cnt_q;
	logic           do_push, do_pop;

	assign push_ready = cnt_q != (AW + 1)'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = slot_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + AW'(1);
			if (do_pop)  rptr_q <= rptr_q + AW'(1);
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (AW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW + 1)'(DEPTH))
		else $error("queue count beyond depth");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && !pop_ready && !do_push |=> pop_valid && $stable(pop_data))
		else $error("queue head changed while stalled");

endmodule

`default_nettype wire

### rtl/core/apw_back.sv
// Back end: running sums, column-sum store, divide by window area, output register.
`default_nettype none

module apw_back #(
	parameter int POOL_SIZE = apw_pkg::POOL_SIZE_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pop_valid,
	output logic                pop_ready,
	input  wire apw_pkg::cmd_t  pop_data,
	apw_pooled_if.source        pooled
);

	localparam int AREA  = POOL_SIZE * POOL_SIZE;
	localparam int SW    = apw_pkg::SAMPLE_W;
	localparam int SUM_W = SW + $clog2(AREA);
	localparam int K     = SUM_W + 4;
	localparam int PW    = SUM_W + K + 1;
	localparam int DEPTH = apw_pkg::SUM_DEPTH;
	// ceil(2^K / AREA): exact floor division for every magnitude below 2^SUM_W
	localparam logic [K:0] RECIP = (K + 1)'(((64'd1 << K) + 64'(AREA) - 64'd1) / 64'(AREA));

	logic signed [SUM_W-1:0] run_sum_q;
	logic                    valid_s1, valid_s2, valid_s3, out_v_q;
	apw_pkg::cmd_t           cmd_s1;
	logic signed [SUM_W-1:0] total_s2;
	apw_pkg::tag_t           tag_s2, tag_s3;
	logic [PW-1:0]           prod_s3;
	logic                    neg_s3;

	logic                    out_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free;
	logic                    pop;
	logic                    ram_we, ram_re;
	logic [SUM_W-1:0]        ram_rdata;
	logic signed [SUM_W-1:0] total_c, sample_ext;
	logic [SUM_W-1:0]        mag_c;
	logic [SW:0]             quot_c, avg_c;

	// elastic chain: each stage advances when the one after it frees up
	assign out_free  = !out_v_q || pooled.ready;
	assign s3_adv    = valid_s3 && out_free;
	assign s3_free   = !valid_s3 || s3_adv;
	assign s2_adv    = valid_s2 && s3_free;
	assign s2_free   = !valid_s2 || s2_adv;
	assign s1_adv    = valid_s1 && s2_free;
	assign s1_free   = !valid_s1 || s1_adv;
	assign pop_ready = s1_free;
	assign pop       = pop_valid && s1_free;

	// read the stored column sum as the window row closes; data lands with s1
	assign ram_re = pop && pop_data.cc_last && !pop_data.rr_first;
	assign ram_we = s1_adv && !cmd_s1.rr_last;

	always_comb begin
		sample_ext = SUM_W'(pop_data.sample);
		// run_sum_q belongs to the s1 word: no pop can replace it while s1 waits
		total_c = run_sum_q + (cmd_s1.rr_first ? '0 : $signed(ram_rdata));
		mag_c   = total_s2[SUM_W-1] ? (~total_s2 + SUM_W'(1)) : total_s2;
		quot_c  = prod_s3[K +: SW + 1];
		avg_c   = neg_s3 ? ((SW + 1)'(0) - quot_c) : quot_c;
	end

	apw_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_col_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd_s1.tag.wc),
		.wdata (total_c),
		.re    (ram_re),
		.raddr (pop_data.tag.wc),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_sum_q <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (pop) begin
				run_sum_q <= pop_data.cc_first ? sample_ext : run_sum_q + sample_ext;
			end
			if (s1_free) valid_s1 <= pop && pop_data.cc_last;
			if (s2_free) valid_s2 <= s1_adv && cmd_s1.rr_last;
			if (s3_free) valid_s3 <= s2_adv;
			if (out_free) out_v_q <= s3_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= pop_data;
		end
		if (s1_adv && cmd_s1.rr_last) begin
			total_s2 <= total_c;
			tag_s2   <= cmd_s1.tag;
		end
		if (s2_adv) begin
			prod_s3 <= PW'(mag_c) * PW'(RECIP);
			neg_s3  <= total_s2[SUM_W-1];
			tag_s3  <= tag_s2;
		end
		if (s3_adv) begin
			pooled.average    <= avg_c[SW-1:0];
			pooled.out_row    <= tag_s3.wr;
			pooled.out_col    <= tag_s3.wc;
			pooled.frame_last <= tag_s3.frame_last;
		end
	end

	assign pooled.valid = out_v_q;

	a_row_close_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && !cmd_s1.rr_last |=> !valid_s2)
		else $error("window row close produced a result word");

	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("column-sum read and write in one cycle");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && out_v_q && !pooled.ready |=> valid_s3 && $stable(prod_s3))
		else $error("divide stage lost its word under stall");

endmodule

`default_nettype wire

### rtl/core/average_pool_window.sv
// Top level: streaming average pooling over non-overlapping square windows.
//
//   channel   kind        word                                   accepted when
//   --------  ----------  -------------------------------------  ------------------------
//   feature   sink        sample (Q8.8, raster order)            valid && ready
//   pooled    source      average, out_row, out_col, frame_last  valid && ready
//   apb       cfg slave   row_length @0x0, row_total @0x4        psel && penable && pwrite
//
// Throughput is one sample word per cycle while feature.ready is high; nothing in the path
// loops back on itself across more than one register, so a window result does not hold up samples.
// After its bottom-right sample is accepted, a result word passes the queue, s1 (pop
// with sum and RAM read), s2 (RAM add), s3 (reciprocal multiply) and the output register.
// Reset clears counters, running sum and valid bits; the column-sum RAM is not
// cleared and needs no clearing pass, since each entry is written before it is read.
// A stalled pooled port fills the back pipeline, then the four-word queue, then
// drops feature.ready; trailing samples outside a whole window only advance counters.
`default_nettype none

module average_pool_window #(
	parameter int POOL_SIZE  = apw_pkg::POOL_SIZE_DEF,
	parameter int MAX_WIDTH  = apw_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = apw_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	apw_feature_if.sink                       feature,
	apw_pooled_if.source                      pooled,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [apw_pkg::APB_AW-1:0]   paddr,
	input  wire logic [apw_pkg::APB_DW-1:0]   pwdata,
	output logic      [apw_pkg::APB_DW-1:0]   prdata,
	output logic                              pready
);

	localparam int CFG_W = apw_pkg::CFG_W;
	localparam int DW    = apw_pkg::APB_DW;

	logic [CFG_W-1:0]  row_length_q, row_total_q;
	logic              cfg_write;
	apw_pkg::reg_idx_t reg_sel;

	logic              push_valid, push_ready, pop_valid, pop_ready;
	apw_pkg::cmd_t     push_data, pop_data;

	// config port: zero wait states, write at the access phase
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_sel   = apw_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= apw_pkg::ROW_LENGTH_RST;
			row_total_q  <= apw_pkg::ROW_TOTAL_RST;
		end else if (cfg_write) begin
			unique case (reg_sel)
				apw_pkg::REG_ROW_LENGTH: row_length_q <= pwdata[CFG_W-1:0];
				apw_pkg::REG_ROW_TOTAL:  row_total_q  <= pwdata[CFG_W-1:0];
				default:                 row_length_q <= row_length_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			apw_pkg::REG_ROW_LENGTH: prdata = DW'(row_length_q);
			apw_pkg::REG_ROW_TOTAL:  prdata = DW'(row_total_q);
			default:                 prdata = '0;
		endcase
	end

	// front: counters and window classification
	apw_front #(
		.POOL_SIZE  (POOL_SIZE),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.feature    (feature),
		.row_length (row_length_q),
		.row_total  (row_total_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouple front and back so each side stalls on its own
	apw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: sums, line store, divide, output word
	apw_back #(
		.POOL_SIZE (POOL_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.pooled    (pooled)
	);

endmodule

`default_nettype wire
